// ----- rtl/bmsh_pkg.sv -----
// ----------------------------------------------------------------------------
// bmsh_pkg
// Shared types and constants for the byte-mixing string hash core.
// ----------------------------------------------------------------------------
package bmsh_pkg;

  // Hash word geometry
  localparam int unsigned WordW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LaneW  = 2;   // byte lane index within the word

  // Finalization rounds run after the last character
  localparam int unsigned FinalRounds = 8;
  localparam int unsigned RoundW      = $clog2(FinalRounds);

  // Control handed to the shared mixing unit for one update
  typedef struct packed {
    logic [LaneW-1:0] dst;     // byte lane being updated
    logic             fin;     // finalization operand pattern
    logic [ByteW-1:0] addend;  // character, zero during finalization
  } mix_ctrl_t;

endpackage

// ----- rtl/bmsh_if.sv -----
// ----------------------------------------------------------------------------
// bmsh_char_if / bmsh_hash_if
// Valid/ready channels for incoming characters and outgoing hash words.
// ----------------------------------------------------------------------------
interface bmsh_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       char_valid;
  logic       end_of_string;

  modport source (output valid, char_byte, char_valid, end_of_string, input ready);
  modport sink   (input valid, char_byte, char_valid, end_of_string, output ready);
endinterface

interface bmsh_hash_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

// ----- rtl/byte_mixing_string_hash_core.sv -----
// ----------------------------------------------------------------------------
// byte_mixing_string_hash_core
// Hashes a string, one character per request, into a 32-bit word seeded
// from a salt register, with eight mixing rounds after the last character.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  char_in   in   valid/ready   char_byte[7:0], char_valid, end_of_string
//  hash_out  out  valid/ready   hash_value[31:0]
//  cfg       in   cfg_we_i      cfg_wdata_i[31:0] (seed salt)
//
//  A character request is taken while the core is idle. A request with
//  end_of_string then occupies the shared mixing unit for the eight rounds,
//  then moves the hash into the output register once that is free; char_in
//  is not ready meanwhile. The output register lets the next string start
//  while a hash waits; a second hash waits in the core until the first is
//  taken. Reset clears the salt, the hash word and all control state.
// ----------------------------------------------------------------------------
module byte_mixing_string_hash_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bmsh_pkg::WordW-1:0] cfg_wdata_i,
  bmsh_char_if.sink                  char_in,
  bmsh_hash_if.source                hash_out
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIN  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [bmsh_pkg::WordW-1:0]  salt_q;
  logic [bmsh_pkg::WordW-1:0]  word_q, word_d;
  logic [bmsh_pkg::LaneW-1:0]  phase_q, phase_d;
  logic                        started_q, started_d;
  logic [bmsh_pkg::RoundW-1:0] rnd_q, rnd_d;
  logic [bmsh_pkg::WordW-1:0]  hash_q, hash_d;
  logic                        out_valid_q, out_valid_d;

  logic                        req_take;
  logic [bmsh_pkg::WordW-1:0]  base_word;
  logic [bmsh_pkg::LaneW-1:0]  base_phase;
  bmsh_pkg::mix_ctrl_t         mix_ctrl;
  logic [bmsh_pkg::WordW-1:0]  mix_word;
  logic                        slot_free;

  assign char_in.ready      = (state_q == S_IDLE);
  assign req_take           = char_in.valid && char_in.ready;
  assign hash_out.valid     = out_valid_q;
  assign hash_out.hash_value = hash_q;
  assign slot_free          = !out_valid_q || hash_out.ready;

  // A new string starts from the salt
  assign base_word  = started_q ? word_q  : salt_q;
  assign base_phase = started_q ? phase_q : '0;

  // Operand select for the shared unit
  always_comb begin
    if (state_q == S_FIN) begin
      mix_ctrl.dst    = rnd_q[bmsh_pkg::LaneW-1:0] + 2'd3;
      mix_ctrl.fin    = 1'b1;
      mix_ctrl.addend = '0;
    end else begin
      mix_ctrl.dst    = base_phase;
      mix_ctrl.fin    = 1'b0;
      mix_ctrl.addend = char_in.char_byte;
    end
  end

  bmsh_mix_unit u_mix (
    .word_i (state_q == S_FIN ? word_q : base_word),
    .ctrl_i (mix_ctrl),
    .word_o (mix_word)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    word_d      = word_q;
    phase_d     = phase_q;
    started_d   = started_q;
    rnd_d       = rnd_q;
    hash_d      = hash_q;
    out_valid_d = out_valid_q && !hash_out.ready;
    unique case (state_q)
      S_IDLE: begin
        if (req_take) begin
          if (char_in.char_valid || char_in.end_of_string) begin
            word_d    = char_in.char_valid ? mix_word : base_word;
            phase_d   = char_in.char_valid ? base_phase + 2'd1 : base_phase;
            started_d = 1'b1;
          end
          if (char_in.end_of_string) begin
            state_d = S_FIN;
            rnd_d   = '0;
          end
        end
      end
      S_FIN: begin
        word_d = mix_word;
        if (rnd_q == bmsh_pkg::RoundW'(bmsh_pkg::FinalRounds - 1)) begin
          rnd_d   = '0;
          state_d = S_HOLD;
        end else begin
          rnd_d = rnd_q + bmsh_pkg::RoundW'(1);
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          hash_d      = word_q;
          out_valid_d = 1'b1;
          word_d      = salt_q;
          phase_d     = '0;
          started_d   = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and hash-word registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      salt_q      <= '0;
      word_q      <= '0;
      phase_q     <= '0;
      started_q   <= 1'b0;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        salt_q <= cfg_wdata_i;
      end
      word_q      <= word_d;
      phase_q     <= phase_d;
      started_q   <= started_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
  end

  // Checks
  a_fin_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_take && char_in.end_of_string) |-> ##9 (state_q == S_HOLD))
    else $error("finalization did not take eight rounds");

  a_rnd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_FIN) |-> (rnd_q == '0))
    else $error("round counter not cleared outside finalization");

  a_hold_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOLD && slot_free) |=> (out_valid_q && state_q == S_IDLE && !started_q))
    else $error("finished hash not moved to output");

endmodule

// ----- rtl/bmsh_mix_unit.sv -----
// ----------------------------------------------------------------------------
// bmsh_mix_unit
// Shared byte update: dst += addend + x*y + z (mod 256), where x, y, z are
// other lanes of the word chosen by the operand pattern.
// ----------------------------------------------------------------------------
module bmsh_mix_unit (
  input  logic [bmsh_pkg::WordW-1:0] word_i,
  input  bmsh_pkg::mix_ctrl_t        ctrl_i,
  output logic [bmsh_pkg::WordW-1:0] word_o
);

  logic [bmsh_pkg::ByteW-1:0]   lane [4];
  logic [bmsh_pkg::LaneW-1:0]   x_idx, y_idx, z_idx;
  logic [2*bmsh_pkg::ByteW-1:0] prod;
  logic [bmsh_pkg::ByteW-1:0]   upd;

  // Split word into lanes, little-endian
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lane[k] = word_i[k*bmsh_pkg::ByteW +: bmsh_pkg::ByteW];
    end
  end

  // Operand lanes: characters use dst+3, dst+2, dst+1;
  // finalization uses dst+1, dst+2, dst+3
  always_comb begin
    y_idx = ctrl_i.dst + 2'd2;
    if (ctrl_i.fin) begin
      x_idx = ctrl_i.dst + 2'd1;
      z_idx = ctrl_i.dst + 2'd3;
    end else begin
      x_idx = ctrl_i.dst + 2'd3;
      z_idx = ctrl_i.dst + 2'd1;
    end
  end

  // One 8x8 multiply and a narrow add chain
  assign prod = lane[x_idx] * lane[y_idx];
  assign upd  = lane[ctrl_i.dst] + ctrl_i.addend + prod[bmsh_pkg::ByteW-1:0]
              + lane[z_idx];

  // Write the updated lane back
  always_comb begin
    word_o = word_i;
    word_o[ctrl_i.dst*bmsh_pkg::ByteW +: bmsh_pkg::ByteW] = upd;
  end

endmodule

// ----- bench/string_hash_checker.sv -----
// ----------------------------------------------------------------------------
// string_hash_checker
// Watches the character and hash channels and the salt port, and keeps its
// own copy of the hash word. Each completed string queues the hash it
// should produce; each hash taken from the core is compared with the
// oldest one queued.
// ----------------------------------------------------------------------------
module string_hash_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bmsh_pkg::WordW-1:0] cfg_wdata_i,
  bmsh_char_if                       char_mon,
  bmsh_hash_if                       hash_mon,
  output int                         mismatch_count,
  output int                         hashes_outstanding
);

  logic [bmsh_pkg::WordW-1:0] salt_q;
  logic [bmsh_pkg::WordW-1:0] word_q;
  logic [bmsh_pkg::LaneW-1:0] lane_q;
  bit                         string_open;
  logic [bmsh_pkg::WordW-1:0] expected_hashes[$];

  // One byte lane of the word; the 2-bit index wraps mod 4
  function automatic logic [bmsh_pkg::ByteW-1:0] lane_of(
      input logic [bmsh_pkg::WordW-1:0] w,
      input logic [bmsh_pkg::LaneW-1:0] k);
    return w[bmsh_pkg::ByteW*k +: bmsh_pkg::ByteW];
  endfunction

  // Fold one character into lane p
  function automatic logic [bmsh_pkg::WordW-1:0] absorb_char(
      input logic [bmsh_pkg::WordW-1:0] w,
      input logic [bmsh_pkg::LaneW-1:0] p,
      input logic [bmsh_pkg::ByteW-1:0] c);
    logic [bmsh_pkg::ByteW-1:0] sum;
    sum = lane_of(w, p) + c + lane_of(w, p + 2'd3) * lane_of(w, p + 2'd2)
          + lane_of(w, p + 2'd1);
    w[bmsh_pkg::ByteW*p +: bmsh_pkg::ByteW] = sum;
    return w;
  endfunction

  // Finalization rounds run on the last request of a string
  function automatic logic [bmsh_pkg::WordW-1:0] final_mix(
      input logic [bmsh_pkg::WordW-1:0] w);
    logic [bmsh_pkg::LaneW-1:0] k;
    logic [bmsh_pkg::LaneW-1:0] dst;
    logic [bmsh_pkg::ByteW-1:0] sum;
    for (int r = 0; r < bmsh_pkg::FinalRounds; r++) begin
      k   = bmsh_pkg::LaneW'(r);
      dst = k + 2'd3;
      sum = lane_of(w, dst) + lane_of(w, k) * lane_of(w, k + 2'd1)
            + lane_of(w, k + 2'd2);
      w[bmsh_pkg::ByteW*dst +: bmsh_pkg::ByteW] = sum;
    end
    return w;
  endfunction

  // Track salt writes, accepted characters and accepted hashes
  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [bmsh_pkg::WordW-1:0] want;
    if (!rst_ni) begin
      salt_q      = '0;
      word_q      = '0;
      lane_q      = '0;
      string_open = 1'b0;
      expected_hashes.delete();
      mismatch_count     = 0;
      hashes_outstanding = 0;
    end else begin
      if (cfg_we_i) salt_q = cfg_wdata_i;

      if (char_mon.valid && char_mon.ready) begin
        // salt is picked up by the first character or an empty string
        if (!string_open && (char_mon.char_valid || char_mon.end_of_string)) begin
          word_q      = salt_q;
          lane_q      = '0;
          string_open = 1'b1;
        end
        if (char_mon.char_valid) begin
          word_q = absorb_char(word_q, lane_q, char_mon.char_byte);
          lane_q = lane_q + 2'd1;
        end
        if (char_mon.end_of_string) begin
          expected_hashes = {expected_hashes, final_mix(word_q)};
          word_q      = salt_q;
          lane_q      = '0;
          string_open = 1'b0;
        end
      end

      if (hash_mon.valid && hash_mon.ready) begin
        if (expected_hashes.size() == 0) begin
          $display("%0t: unexpected hash %08h", $time, hash_mon.hash_value);
          mismatch_count++;
        end else begin
          want = expected_hashes.pop_front();
          if (hash_mon.hash_value !== want) begin
            $display("%0t: hash_value expected %08h actual %08h",
                     $time, want, hash_mon.hash_value);
            mismatch_count++;
          end
        end
      end

      hashes_outstanding = expected_hashes.size();
    end
  end

endmodule

// ----- bench/byte_mixing_string_hash_core_test.sv -----
// ----------------------------------------------------------------------------
// byte_mixing_string_hash_core_test
// Drives strings into the hash core under bursty input and a stalling
// output, through a series of salt settings, and lets the checker compare
// every hash. Directed strings cover the extremes first, then random ones.
// ----------------------------------------------------------------------------
module byte_mixing_string_hash_core_test;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic [bmsh_pkg::WordW-1:0] cfg_wdata;
  int                         mismatch_count;
  int                         hashes_outstanding;

  bmsh_char_if char_if ();
  bmsh_hash_if hash_if ();

  byte_mixing_string_hash_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .char_in    (char_if),
    .hash_out   (hash_if)
  );

  string_hash_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .char_mon          (char_if),
    .hash_mon          (hash_if),
    .mismatch_count    (mismatch_count),
    .hashes_outstanding(hashes_outstanding)
  );

  always #5 clk = ~clk;

  // Run limit
  initial begin
    #5_000_000;
    $display("byte_mixing_string_hash_core_test: FAIL");
    $finish;
  end

  // Hash receiver: picks a new random stall pattern whenever the last one runs out
  int stall_left = 0;
  int stall_mode = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 80);
    end
    stall_left--;
    case (stall_mode)
      0: begin
        hash_if.ready <= 1'b1;
      end
      1: begin
        hash_if.ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        hash_if.ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        hash_if.ready <= (stall_left % 12 == 0);
      end
    endcase
  end

  int burst_left = 0;
  bit no_gaps    = 1'b1;
  int chars_sent = 0;

  // One request; gaps fall between random bursts unless no_gaps is set
  task automatic send_req(input logic [7:0] c, input logic cv, input logic eos);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = $urandom_range(1, 6);
      @(negedge clk);
      char_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    char_if.valid         <= 1'b1;
    char_if.char_byte     <= c;
    char_if.char_valid    <= cv;
    char_if.end_of_string <= eos;
    do @(posedge clk); while (!char_if.ready);
    if (cv || eos) chars_sent++;
  endtask

  // Stop sending and wait for every queued hash, then idle on
  task automatic wait_idle();
    @(negedge clk);
    char_if.valid <= 1'b0;
    while (hashes_outstanding != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_salt(input logic [bmsh_pkg::WordW-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Random string, with ignored empty requests mixed in now and then
  task automatic send_string(input int n_chars, input bit end_blank);
    for (int i = 0; i < n_chars; i++) begin
      if ($urandom_range(0, 7) == 0) send_req(8'($urandom), 1'b0, 1'b0);
      send_req(pick_char(), 1'b1, (i == n_chars - 1) && !end_blank);
    end
    if (end_blank) send_req(8'($urandom), 1'b0, 1'b1);
  endtask

  // Stimulus
  initial begin
    logic [bmsh_pkg::WordW-1:0] salts[6];
    int                         target;
    int                         n;

    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    char_if.valid         = 1'b0;
    char_if.char_byte     = '0;
    char_if.char_valid    = 1'b0;
    char_if.end_of_string = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset salt: empty string, then an ignored request and a zero char
    send_req(8'h00, 1'b0, 1'b1);
    send_req(8'hFF, 1'b0, 1'b0);
    send_req(8'h00, 1'b1, 1'b1);
    wait_idle();

    // All-ones salt: five all-ones chars wrap the lane index
    write_salt(32'hFFFF_FFFF);
    repeat (4) send_req(8'hFF, 1'b1, 1'b0);
    send_req(8'hFF, 1'b1, 1'b1);
    send_req(8'hA5, 1'b0, 1'b1);
    wait_idle();

    // Mixed salt: chars with an empty request inside, blank last request
    write_salt(32'h8000_0001);
    send_req(8'h00, 1'b1, 1'b0);
    send_req(8'h01, 1'b1, 1'b0);
    send_req(8'h3C, 1'b0, 1'b0);
    send_req(8'h80, 1'b1, 1'b0);
    send_req(8'h7F, 1'b1, 1'b0);
    send_req(8'h55, 1'b0, 1'b1);
    send_req(8'hAA, 1'b1, 1'b1);
    wait_idle();

    // Zero salt written back
    write_salt(32'h0000_0000);
    send_req(8'h00, 1'b0, 1'b1);
    send_req(8'hFF, 1'b1, 1'b0);
    send_req(8'h00, 1'b1, 1'b1);
    wait_idle();

    // Random strings through several salts
    salts[0] = 32'hFFFF_FFFF;
    salts[1] = $urandom;
    salts[2] = 32'h0000_0000;
    salts[3] = $urandom;
    salts[4] = 32'h8000_0000;
    salts[5] = $urandom;
    target   = chars_sent;
    foreach (salts[p]) begin
      write_salt(salts[p]);
      no_gaps    = ($urandom_range(0, 3) == 0);
      burst_left = 0;
      target    += 115;
      while (chars_sent < target) begin
        case ($urandom_range(0, 9))
          0:       n = 0;
          9:       n = $urandom_range(13, 40);
          default: n = $urandom_range(1, 12);
        endcase
        send_string(n, (n == 0) || ($urandom_range(0, 4) == 0));
        if ($urandom_range(0, 29) == 0) wait_idle();
      end
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("byte_mixing_string_hash_core_test: PASS");
    end else begin
      $display("byte_mixing_string_hash_core_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- byte_mixing_string_hash_core.f -----
rtl/bmsh_pkg.sv
rtl/bmsh_if.sv
rtl/bmsh_mix_unit.sv
rtl/byte_mixing_string_hash_core.sv
bench/string_hash_checker.sv
bench/byte_mixing_string_hash_core_test.sv
